// ----- hdl/srer_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srer_pkg
// Types, constants and helpers shared by the serial record escape receiver.
// ----------------------------------------------------------------------------
package srer_pkg;

    // Buffer geometry
    localparam int BUFFER_DEPTH = 16384;
    localparam int IDX_W        = 14;
    localparam logic [IDX_W-1:0] ADDR_MASK =
        (BUFFER_DEPTH >= (1 << IDX_W)) ? {IDX_W{1'b1}} : IDX_W'(BUFFER_DEPTH - 1);

    // Register indexes
    localparam logic [1:0] REG_FRAME_MODE      = 2'd0;
    localparam logic [1:0] REG_RAW_COUNT       = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH      = 2'd2;
    localparam logic [1:0] REG_ESCAPE_LIMIT    = 2'd3;

    // Register reset values
    localparam logic [13:0] MAX_LENGTH_RESET   = 14'h2328;
    localparam logic [8:0]  ESCAPE_LIMIT_RESET = 9'h12e;

    // Record modes
    localparam logic [1:0] MODE_ANY_ZERO = 2'd0;
    localparam logic [1:0] MODE_ESCAPES  = 2'd1;

    // Escape bytes
    localparam logic [7:0] BYTE_EXTENSION = 8'd20;
    localparam logic [7:0] BYTE_ESCAPE    = 8'd18;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_EXTENSION,
        PH_ESCAPE,
        PH_CHECKSUM
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [IDX_W-1:0] write_index;
        logic [7:0]       extension_left;
        logic [8:0]       escape_seen;
    } rec_state_t;

    typedef struct packed {
        logic [1:0]  frame_mode;
        logic [7:0]  raw_count;
        logic [13:0] max_length;
        logic [8:0]  escape_limit;
    } cfg_t;

    typedef struct packed {
        logic             write_enable;
        logic [IDX_W-1:0] write_address;
        logic [7:0]       write_data;
        logic             record_done;
        logic             aborted;
        logic [IDX_W-1:0] record_length;
        logic [7:0]       checksum_byte;
    } result_t;

    localparam rec_state_t STATE_RESET = '{
        phase:          PH_NORMAL,
        write_index:    '0,
        extension_left: '0,
        escape_seen:    '0
    };

    function automatic logic [IDX_W-1:0] buf_addr(input logic [IDX_W-1:0] idx);
        return idx & ADDR_MASK;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/serial_record_escape_receiver_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serial_record_escape_receiver_top
// Frames received serial bytes into buffered records with escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready/s_rx_byte): one received byte per
//   transaction. Every accepted byte yields exactly one result transaction
//   on the m_ channel: a buffer write (enable, address, data) and/or, when the
//   record finishes, record_done with its length and checksum byte, or
//   record_done with aborted when the escape limit is reached.
//   The result of a byte accepted at one edge is registered and valid
//   after that edge. Throughput is one byte per cycle unless m_ready stalls
//   the output; the record state updates in a single pass of the step logic
//   and the result register takes a new transaction when empty or draining.
//   When the receiver stalls (m_ready low with m_valid high), s_ready drops
//   and the held result stays unchanged until it is taken.
//   Configuration (cfg_we/cfg_index/cfg_data) writes a register at once;
//   write only while no transaction is in flight.
//   Reset (aresetn low, synchronous) clears the record state, empties the
//   result register and restores the register defaults: mode 0, extension
//   count 0, max length 9000, escape limit 302.
// ----------------------------------------------------------------------------
module serial_record_escape_receiver_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data,

    // received bytes
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    // per-byte results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_write_enable,
    output logic [13:0]      m_write_address,
    output logic [7:0]       m_write_data,
    output logic             m_record_done,
    output logic             m_aborted,
    output logic [13:0]      m_record_length,
    output logic [7:0]       m_checksum_byte
);

    srer_pkg::cfg_t       cfg_reg;
    srer_pkg::rec_state_t state_reg;
    srer_pkg::rec_state_t state_next;
    srer_pkg::result_t    result_next;
    srer_pkg::result_t    result_reg;
    logic                 m_valid_reg;
    logic                 s_accept;

    // Result register empty or draining this cycle: take a new byte.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    srer_step u_step (
        .state_i  (state_reg),
        .cfg_i    (cfg_reg),
        .rx_byte  (s_rx_byte),
        .state_o  (state_next),
        .result_o (result_next)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_mode      <= srer_pkg::MODE_ANY_ZERO;
            cfg_reg.raw_count       <= 8'd0;
            cfg_reg.max_length      <= srer_pkg::MAX_LENGTH_RESET;
            cfg_reg.escape_limit    <= srer_pkg::ESCAPE_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                srer_pkg::REG_FRAME_MODE:      cfg_reg.frame_mode      <= cfg_data[1:0];
                srer_pkg::REG_RAW_COUNT:       cfg_reg.raw_count       <= cfg_data[7:0];
                srer_pkg::REG_MAX_LENGTH:      cfg_reg.max_length      <= cfg_data;
                srer_pkg::REG_ESCAPE_LIMIT:    cfg_reg.escape_limit    <= cfg_data[8:0];
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Record state advances once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srer_pkg::STATE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register: valid is control, payload loads on accept only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = result_reg.write_enable;
    assign m_write_address = result_reg.write_address;
    assign m_write_data    = result_reg.write_data;
    assign m_record_done   = result_reg.record_done;
    assign m_aborted       = result_reg.aborted;
    assign m_record_length = result_reg.record_length;
    assign m_checksum_byte = result_reg.checksum_byte;

endmodule
`default_nettype wire

// ----- hdl/srer_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srer_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module srer_step (
    input  wire srer_pkg::rec_state_t state_i,
    input  wire srer_pkg::cfg_t       cfg_i,
    input  wire logic [7:0]           rx_byte,
    output srer_pkg::rec_state_t      state_o,
    output srer_pkg::result_t         result_o
);

    logic [13:0] idx_inc;
    logic [8:0]  esc_inc;
    logic        zero_ends;

    assign idx_inc   = state_i.write_index + 14'd1;
    assign esc_inc   = state_i.escape_seen + 9'd1;
    assign zero_ends = (rx_byte == 8'd0) &&
                       ((cfg_i.frame_mode == srer_pkg::MODE_ANY_ZERO) ||
                        (state_i.write_index > 14'd1));

    always_comb begin
        state_o  = state_i;
        result_o = '0;
        unique case (state_i.phase)
            srer_pkg::PH_CHECKSUM: begin
                result_o.record_done   = 1'b1;
                result_o.record_length = state_i.write_index;
                result_o.checksum_byte = rx_byte;
                state_o                = srer_pkg::STATE_RESET;
            end
            srer_pkg::PH_EXTENSION: begin
                result_o.write_enable   = 1'b1;
                result_o.write_address  = srer_pkg::buf_addr(state_i.write_index);
                result_o.write_data     = rx_byte;
                state_o.write_index     = idx_inc;
                state_o.extension_left  = state_i.extension_left - 8'd1;
                if (state_i.extension_left == 8'd1) begin
                    state_o.phase = srer_pkg::PH_NORMAL;
                end
            end
            srer_pkg::PH_ESCAPE: begin
                result_o.write_enable  = 1'b1;
                result_o.write_address = srer_pkg::buf_addr(state_i.write_index);
                result_o.write_data    = rx_byte;
                if (esc_inc >= cfg_i.escape_limit) begin
                    result_o.record_done = 1'b1;
                    result_o.aborted     = 1'b1;
                    state_o              = srer_pkg::STATE_RESET;
                end else begin
                    state_o.write_index = idx_inc;
                    state_o.escape_seen = esc_inc;
                    state_o.phase       = srer_pkg::PH_NORMAL;
                end
            end
            default: begin
                priority if (state_i.write_index >= cfg_i.max_length) begin
                    // length limit: this byte is the checksum
                    result_o.record_done   = 1'b1;
                    result_o.record_length = state_i.write_index;
                    result_o.checksum_byte = rx_byte;
                    state_o                = srer_pkg::STATE_RESET;
                end else if (zero_ends) begin
                    result_o.write_enable  = 1'b1;
                    result_o.write_address = srer_pkg::buf_addr(state_i.write_index);
                    state_o.phase          = srer_pkg::PH_CHECKSUM;
                end else begin
                    result_o.write_enable  = 1'b1;
                    result_o.write_address = srer_pkg::buf_addr(state_i.write_index);
                    result_o.write_data    = rx_byte;
                    state_o.write_index    = idx_inc;
                    if (cfg_i.frame_mode == srer_pkg::MODE_ESCAPES) begin
                        if (rx_byte == srer_pkg::BYTE_EXTENSION) begin
                            if (cfg_i.raw_count != 8'd0) begin
                                state_o.extension_left = cfg_i.raw_count;
                                state_o.phase          = srer_pkg::PH_EXTENSION;
                            end
                        end else if (rx_byte == srer_pkg::BYTE_ESCAPE) begin
                            state_o.phase = srer_pkg::PH_ESCAPE;
                        end
                    end
                end
            end
        endcase
    end

endmodule
`default_nettype wire
